[design/esp_pkg.sv]
// ----------------------------------------------------------------------------
// esp_pkg
// Shared types and constants for the encoder speed PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package esp_pkg;

	// target saturation bound, rpm (integer part)
	localparam int unsigned TARGET_LIMIT_RPM = 512;
	localparam int unsigned TMAX_Q8 = TARGET_LIMIT_RPM * 256;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 39;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_RPM_PER_COUNT  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_GAIN    = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P         = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I         = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D         = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GATE  = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_BOUND = 4'd7;

	localparam logic [15:0] FILTER_GAIN_RST  = 16'hFFFF;
	localparam logic [14:0] OUTPUT_LIMIT_RST = 15'd25600;

	typedef struct packed {
		logic [23:0] rpm_per_count;
		logic [15:0] filter_gain;
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [23:0] integral_gate;
		logic [14:0] output_limit;
		logic [38:0] integral_bound;
	} cfg_t;

	// datapath operations, one per sequencer step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_RAW,
		OP_RAW,
		OP_MUL_FLT,
		OP_UPD_SE,
		OP_ERR,
		OP_SUM,
		OP_MUL_P,
		OP_MUL_D,
		OP_MUL_IL,
		OP_MUL_IH,
		OP_ACC_LAST,
		OP_DRIVE
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RAW,
		ST_RAW,
		ST_MUL_FLT,
		ST_UPD_SE,
		ST_ERR,
		ST_SUM,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_IL,
		ST_MUL_IH,
		ST_ACC_LAST,
		ST_DRIVE
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic out_busy;  // result register full and not taken this cycle
	} stat_t;

endpackage

`default_nettype wire

[design/encoder_speed_pid.sv]
// ----------------------------------------------------------------------------
// encoder_speed_pid
// Wheel speed PID controller: scales and low-pass filters encoder deltas,
// runs a gated-integral PID step and saturates the drive.
// ----------------------------------------------------------------------------
//
//  channel  | direction | beat contents (low bits first)
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | count_delta[15:0], target_speed[39:16]
//  m_*      | out       | drive_percent[15:0], filtered_rpm[39:16]
//  cfg_*    | in        | cfg_index = register index 0..7, cfg_data = value
//
//  Steps: accept, 11 datapath steps and result write per item, set by the
//  one shared 26x17 multiplier (six products) and the filter -> error ->
//  integral chain; a new item is taken only after the result write.
//  Reset: arst_n clears speed estimate, last error and integral and loads
//  register defaults; no clearing pass.
//  Stalls: a held result beat blocks the next item's result write and input.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_pid #(
	parameter int unsigned TGT_LIMIT_RPM = esp_pkg::TARGET_LIMIT_RPM
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,    // count_delta[15:0], target_speed[39:16]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,    // drive_percent[15:0], filtered_rpm[39:16]
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [38:0] cfg_data
);
	import esp_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// register file; cfg_ready is always high, writes are meant for idle periods
	esp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: owns s_tready, issues one op per cycle unless a result stall holds it
	esp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, loop state, result register
	esp_dp #(
		.TGT_LIMIT_RPM (TGT_LIMIT_RPM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

[design/esp_cfg.sv]
// ----------------------------------------------------------------------------
// esp_cfg
// Configuration register file; values masked to register width.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [esp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [esp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output esp_pkg::cfg_t                         cfg
);
	import esp_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                <= '0;
			cfg_q.filter_gain    <= FILTER_GAIN_RST;
			cfg_q.output_limit   <= OUTPUT_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RPM_PER_COUNT:  cfg_q.rpm_per_count  <= cfg_data[23:0];
				REG_FILTER_GAIN:    cfg_q.filter_gain    <= cfg_data[15:0];
				REG_GAIN_P:         cfg_q.gain_p         <= cfg_data[15:0];
				REG_GAIN_I:         cfg_q.gain_i         <= cfg_data[15:0];
				REG_GAIN_D:         cfg_q.gain_d         <= cfg_data[15:0];
				REG_INTEGRAL_GATE:  cfg_q.integral_gate  <= cfg_data[23:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_data[14:0];
				REG_INTEGRAL_BOUND: cfg_q.integral_bound <= cfg_data[38:0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

endmodule

`default_nettype wire

[design/esp_ctrl.sv]
// ----------------------------------------------------------------------------
// esp_ctrl
// Step sequencer: issues one datapath operation per cycle per item, except while it waits for input or a busy result.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire esp_pkg::stat_t stat,
	output esp_pkg::cmd_t       cmd
);
	import esp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_MUL_RAW;
			ST_MUL_RAW:  state_d = ST_RAW;
			ST_RAW:      state_d = ST_MUL_FLT;
			ST_MUL_FLT:  state_d = ST_UPD_SE;
			ST_UPD_SE:   state_d = ST_ERR;
			ST_ERR:      state_d = ST_SUM;
			ST_SUM:      state_d = ST_MUL_P;
			ST_MUL_P:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_MUL_IL;
			ST_MUL_IL:   state_d = ST_MUL_IH;
			ST_MUL_IH:   state_d = ST_ACC_LAST;
			ST_ACC_LAST: state_d = ST_DRIVE;
			ST_DRIVE:    if (!stat.out_busy) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_MUL_RAW:  cmd.op = OP_MUL_RAW;
			ST_RAW:      cmd.op = OP_RAW;
			ST_MUL_FLT:  cmd.op = OP_MUL_FLT;
			ST_UPD_SE:   cmd.op = OP_UPD_SE;
			ST_ERR:      cmd.op = OP_ERR;
			ST_SUM:      cmd.op = OP_SUM;
			ST_MUL_P:    cmd.op = OP_MUL_P;
			ST_MUL_D:    cmd.op = OP_MUL_D;
			ST_MUL_IL:   cmd.op = OP_MUL_IL;
			ST_MUL_IH:   cmd.op = OP_MUL_IH;
			ST_ACC_LAST: cmd.op = OP_ACC_LAST;
			ST_DRIVE:    if (!stat.out_busy) cmd.op = OP_DRIVE;
			default:     cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

[design/esp_dp.sv]
// ----------------------------------------------------------------------------
// esp_dp
// Datapath: one shared 26x17 signed multiplier, accumulator, filter and
// PID state, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_dp #(
	parameter int unsigned TGT_LIMIT_RPM = esp_pkg::TARGET_LIMIT_RPM
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire esp_pkg::cmd_t cmd,
	output esp_pkg::stat_t     stat,
	input  wire esp_pkg::cfg_t cfg,
	input  wire logic [39:0]   in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [39:0]        out_data
);
	import esp_pkg::*;

	localparam logic signed [23:0] TMAX   = 24'(TGT_LIMIT_RPM * 256);
	localparam logic signed [23:0] S24MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] S24MIN = -24'sh800000;

	// item registers
	logic signed [15:0] delta_q;
	logic signed [23:0] tgt_q;
	logic               tzero_q;
	logic signed [23:0] raw_q;
	logic signed [24:0] err_q;
	logic signed [25:0] deriv_q;
	logic signed [42:0] prod_q;
	logic               hi_q;     // product belongs to the upper integral half
	logic signed [63:0] acc_q;

	// controller state
	logic signed [23:0] se_q;
	logic signed [24:0] last_q;
	logic signed [39:0] sum_q;

	// result register
	logic signed [15:0] drive_q;
	logic signed [23:0] frpm_q;
	logic               out_valid_q;

	// ---------------- multiplier operands
	logic signed [25:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [42:0] prod_c;
	logic signed [24:0] diff_c;

	assign diff_c = 25'(raw_q) - 25'(se_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_RAW: begin
				mul_a = $signed({2'b00, cfg.rpm_per_count});
				mul_b = 17'(delta_q);
			end
			OP_MUL_FLT: begin
				mul_a = 26'(diff_c);
				mul_b = $signed({1'b0, cfg.filter_gain});
			end
			OP_MUL_P: begin
				mul_a = 26'(err_q);
				mul_b = $signed({1'b0, cfg.gain_p});
			end
			OP_MUL_D: begin
				mul_a = deriv_q;
				mul_b = $signed({1'b0, cfg.gain_d});
			end
			OP_MUL_IL: begin
				mul_a = $signed({6'b0, sum_q[19:0]});
				mul_b = $signed({1'b0, cfg.gain_i});
			end
			OP_MUL_IH: begin
				mul_a = 26'($signed(sum_q[39:20]));
				mul_b = $signed({1'b0, cfg.gain_i});
			end
			default: ;
		endcase
	end

	assign prod_c = mul_a * mul_b;

	// ---------------- raw speed: round by 2^8, saturate to 24 bits
	logic signed [42:0] raw_rnd;
	logic signed [34:0] raw_full;
	logic signed [23:0] raw_c;

	assign raw_rnd  = prod_q + 43'sd128;
	assign raw_full = raw_rnd[42:8];

	always_comb begin
		if (raw_full > 35'(S24MAX))      raw_c = S24MAX;
		else if (raw_full < 35'(S24MIN)) raw_c = S24MIN;
		else                             raw_c = raw_full[23:0];
	end

	// ---------------- filter update: round by 2^16, saturate
	logic signed [42:0] flt_rnd;
	logic signed [27:0] se_full;
	logic signed [23:0] se_c;

	assign flt_rnd = prod_q + 43'sd32768;
	assign se_full = 28'(se_q) + 28'($signed(flt_rnd[42:16]));

	always_comb begin
		if (se_full > 28'(S24MAX))      se_c = S24MAX;
		else if (se_full < 28'(S24MIN)) se_c = S24MIN;
		else                            se_c = se_full[23:0];
	end

	// ---------------- target clamp at load
	logic signed [23:0] tin;
	logic signed [23:0] tgt_c;

	assign tin = in_data[39:16];

	always_comb begin
		if (tin > TMAX)       tgt_c = TMAX;
		else if (tin < -TMAX) tgt_c = -TMAX;
		else                  tgt_c = tin;
	end

	// ---------------- error and derivative
	logic signed [24:0] err_c;
	logic signed [25:0] deriv_c;

	assign err_c   = 25'(tgt_q) - 25'(se_q);
	assign deriv_c = 26'(err_c) - 26'(last_q);

	// ---------------- integral gate and clamp
	logic [24:0]        mag_c;
	logic               gate_open;
	logic signed [40:0] sum_full;
	logic signed [40:0] bound_c;
	logic signed [39:0] sum_c;

	assign mag_c     = err_q[24] ? 25'(-err_q) : 25'(err_q);
	assign gate_open = (cfg.gain_i != 16'd0) && (mag_c < {1'b0, cfg.integral_gate});
	assign sum_full  = 41'(sum_q) + 41'(err_q);
	assign bound_c   = $signed({2'b00, cfg.integral_bound});

	always_comb begin
		if (sum_full > bound_c)       sum_c = bound_c[39:0];
		else if (sum_full < -bound_c) sum_c = 40'(-bound_c);
		else                          sum_c = sum_full[39:0];
	end

	// ---------------- accumulator input
	logic signed [63:0] prod_ext;

	assign prod_ext = hi_q ? (64'(prod_q) <<< 20) : 64'(prod_q);

	// ---------------- drive: round by 2^8, clamp to output limit, zero for a zero target
	logic signed [63:0] acc_rnd;
	logic signed [55:0] drv_full;
	logic signed [55:0] lim_c;
	logic signed [15:0] drive_c;

	assign acc_rnd  = acc_q + 64'sd128;
	assign drv_full = acc_rnd[63:8];
	assign lim_c    = $signed({41'b0, cfg.output_limit});

	always_comb begin
		if (tzero_q)                drive_c = '0;
		else if (drv_full > lim_c)  drive_c = lim_c[15:0];
		else if (drv_full < -lim_c) drive_c = 16'(-lim_c);
		else                        drive_c = drv_full[15:0];
	end

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				delta_q <= in_data[15:0];
				tgt_q   <= tgt_c;
				tzero_q <= (tgt_c == 24'sd0);
			end
			OP_MUL_RAW, OP_MUL_FLT: begin
				prod_q <= prod_c;
				hi_q   <= 1'b0;
			end
			OP_RAW: raw_q <= raw_c;
			OP_ERR: begin
				err_q   <= err_c;
				deriv_q <= deriv_c;
			end
			OP_MUL_P: begin
				prod_q <= prod_c;
				hi_q   <= 1'b0;
				acc_q  <= '0;
			end
			OP_MUL_D, OP_MUL_IL, OP_MUL_IH: begin
				prod_q <= prod_c;
				hi_q   <= (cmd.op == OP_MUL_IH);
				acc_q  <= acc_q + prod_ext;
			end
			OP_ACC_LAST: acc_q <= acc_q + prod_ext;
			OP_DRIVE: begin
				drive_q <= drive_c;
				frpm_q  <= se_q;
			end
			default: ;
		endcase
	end

	// ---------------- loop state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			se_q        <= '0;
			last_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_UPD_SE) se_q <= se_c;
			if (cmd.op == OP_SUM) begin
				if (tzero_q) begin
					last_q <= '0;
					sum_q  <= '0;
				end else begin
					last_q <= err_q;
					sum_q  <= gate_open ? sum_c : 40'sd0;
				end
			end
			if (cmd.op == OP_DRIVE)  out_valid_q <= 1'b1;
			else if (out_ready)      out_valid_q <= 1'b0;
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = {frpm_q, drive_q};

endmodule

`default_nettype wire

[design/esp_checker.sv]
// ----------------------------------------------------------------------------
// esp_checker
// Port-level checks for encoder_speed_pid, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one item at a time: no accept right after an accept
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// a fresh result means the sequencer is back to taking input
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result appeared without sequencer returning to idle");

	// register writes never back-pressure
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind encoder_speed_pid esp_checker u_esp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

[tb/tb_encoder_speed_pid.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_speed_pid
// Self-checking bench for the encoder speed PID controller. A clocked driver
// feeds control ticks from a queue and a clocked monitor checks every result
// beat, field by field, against a cycle-free model of the filter and PID
// step. Register settings change between phases while the block is idle.
// Both stream sides idle at random, and one long result stall backs up the
// input side.
// ----------------------------------------------------------------------------

module tb_encoder_speed_pid;

	import esp_pkg::*;

	localparam int CLK_HALF         = 5;
	localparam int RESET_CYCLES     = 4;
	localparam int DRAIN_CYCLES     = 20;    // settle time after the last result
	localparam int LONG_HOLD_CYCLES = 300;   // far longer than the two-deep pipe
	localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no beat on any channel
	localparam int RANDOM_PHASES    = 12;

	localparam longint RPM_MAX    = 8388607;
	localparam longint RPM_MIN    = -8388608;
	localparam longint TARGET_MAX = longint'(TMAX_Q8);
	localparam int     TMAX       = int'(TMAX_Q8);

	// expected result beat, drive in the low bits as on m_tdata
	typedef struct packed {
		logic [23:0] rpm;
		logic [15:0] drive;
	} ctrl_out_t;

	typedef struct {
		logic [3:0]  idx;
		logic [38:0] val;
	} reg_wr_t;

	// ------------------------------------------------------------------------
	// DUT ports; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // count_delta[15:0], target_speed[39:16]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // drive_percent[15:0], filtered_rpm[39:16]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [38:0] cfg_data  = '0;

	encoder_speed_pid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------------
	// Model state: register file plus the three loop memories, at the
	// block's own widths
	// ------------------------------------------------------------------------
	cfg_t                regs;
	logic signed [23:0]  speed_est;
	logic signed [24:0]  prev_err;
	logic signed [39:0]  err_acc;

	logic [39:0]  tick_queue[$];     // ticks waiting for the driver
	ctrl_out_t    exp_outputs[$];    // predicted results, oldest first
	reg_wr_t      reg_writes[$];

	// handshake flags set by the stimulus process (nonblocking only)
	logic jitter_on     = 1'b1;
	logic long_hold_req = 1'b0;

	int mismatches   = 0;
	int ticks_in     = 0;
	int results_seen = 0;
	int cfg_writes   = 0;
	int settings     = 0;
	int integ_ticks  = 0;
	int sat_ticks    = 0;
	int clear_ticks  = 0;

	// ------------------------------------------------------------------------
	// Fixed-point helpers: shift right with round-half-up, and saturation
	// ------------------------------------------------------------------------
	function automatic longint round_sh(input longint x, input int sh);
		return (x + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void regs_to_reset();
		regs                = '0;
		regs.filter_gain    = FILTER_GAIN_RST;
		regs.output_limit   = OUTPUT_LIMIT_RST;
		speed_est           = '0;
		prev_err            = '0;
		err_acc             = '0;
	endfunction

	// register write as the block sees it: masked to width, junk index dropped
	function automatic void apply_reg_write(input logic [3:0] idx, input logic [38:0] val);
		case (idx)
			REG_RPM_PER_COUNT:  regs.rpm_per_count  = val[23:0];
			REG_FILTER_GAIN:    regs.filter_gain    = val[15:0];
			REG_GAIN_P:         regs.gain_p         = val[15:0];
			REG_GAIN_I:         regs.gain_i         = val[15:0];
			REG_GAIN_D:         regs.gain_d         = val[15:0];
			REG_INTEGRAL_GATE:  regs.integral_gate  = val[23:0];
			REG_OUTPUT_LIMIT:   regs.output_limit   = val[14:0];
			REG_INTEGRAL_BOUND: regs.integral_bound = val[38:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// One control tick: scale and filter the delta, then the gated PID step.
	// Updates the loop state and returns the result beat.
	// ------------------------------------------------------------------------
	function automatic ctrl_out_t pid_tick_model(input logic [39:0] beat);
		ctrl_out_t o;
		longint delta, target, raw, se, err, deriv, acc, drv, bnd, lim, mag, sum, pre;
		delta  = longint'($signed(beat[15:0]));
		target = longint'($signed(beat[39:16]));

		// counts -> rpm, saturating at 24 bits
		raw = clip(round_sh(delta * longint'(regs.rpm_per_count), 8), RPM_MIN, RPM_MAX);

		// first-order low-pass
		se = longint'(speed_est);
		se = clip(se + round_sh(longint'(regs.filter_gain) * (raw - se), 16),
			RPM_MIN, RPM_MAX);
		speed_est = se[23:0];

		target = clip(target, -TARGET_MAX, TARGET_MAX);
		drv = 0;
		if (target == 0) begin
			// zero target clears the controller memory, drive stays 0
			prev_err = '0;
			err_acc  = '0;
			clear_ticks++;
		end else begin
			err      = target - se;
			deriv    = err - longint'(prev_err);
			prev_err = err[24:0];
			mag      = (err < 0) ? -err : err;
			if (regs.gain_i != '0 && mag < longint'(regs.integral_gate)) begin
				bnd     = longint'(regs.integral_bound);
				sum     = clip(longint'(err_acc) + err, -bnd, bnd);
				err_acc = sum[39:0];
				integ_ticks++;
			end else begin
				// gate closed or integral disabled: restart from zero
				err_acc = '0;
			end
			acc = longint'(regs.gain_p) * err +
			      longint'(regs.gain_i) * longint'(err_acc) +
			      longint'(regs.gain_d) * deriv;
			lim = longint'(regs.output_limit);
			pre = round_sh(acc, 8);
			drv = clip(pre, -lim, lim);
			if (drv != pre)
				sat_ticks++;
		end
		o.drive = drv[15:0];
		o.rpm   = se[23:0];
		return o;
	endfunction

	task automatic flag_error(input string what, input longint got, input longint want);
		mismatches++;
		$display("ERROR %0t result %0d %s: got %0d, expected %0d",
			$time, results_seen, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Driver: offers queued ticks on s_*, predicts each accepted beat
	// ------------------------------------------------------------------------
	int        send_gap = 0;
	ctrl_out_t pred;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				pred = pid_tick_model(s_tdata);
				exp_outputs.push_back(pred);
				ticks_in++;
			end
			// the slot is free once the current beat went through
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (tick_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= tick_queue.pop_front();
					if (jitter_on && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 12);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks result beats and drives m_tready (random stalls plus
	// one long hold that fills the block and stalls its input)
	// ------------------------------------------------------------------------
	int        stall_left     = 0;
	int        hold_left      = 0;
	logic      long_hold_done = 1'b0;
	ctrl_out_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (exp_outputs.size() == 0) begin
					flag_error("beat with no tick outstanding", longint'(m_tdata), 0);
				end else begin
					want = exp_outputs.pop_front();
					if (m_tdata[15:0] !== want.drive)
						flag_error("drive_percent", longint'($signed(m_tdata[15:0])),
							longint'($signed(want.drive)));
					if (m_tdata[39:16] !== want.rpm)
						flag_error("filtered_rpm", longint'($signed(m_tdata[39:16])),
							longint'($signed(want.rpm)));
				end
			end

			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (jitter_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: no beat on any channel for too long ends the run
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TIMEOUT after %0d idle cycles, %0d ticks in, %0d results",
					quiet_cycles, ticks_in, results_seen);
				$display("tb_encoder_speed_pid: done, errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_tick(input int delta, input int target);
		logic [15:0] d;
		logic [23:0] t;
		d = delta[15:0];
		t = target[23:0];
		tick_queue.push_back({t, d});
	endtask

	task automatic queue_reg_write(input logic [3:0] idx, input logic [38:0] val);
		reg_wr_t w;
		w.idx = idx;
		w.val = val;
		reg_writes.push_back(w);
	endtask

	// called on a rising edge; cfg_valid stays high across back-to-back writes
	task automatic flush_reg_writes();
		reg_wr_t w;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data  <= w.val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			apply_reg_write(w.idx, w.val);
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// block idle: nothing queued, nothing offered, nothing outstanding
	task automatic wait_quiet();
		while (tick_queue.size() != 0 || s_tvalid || exp_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mix of zero, all-ones (masked to width), full random and moderate values
	// that keep the loop out of permanent saturation.
	task automatic queue_random_settings();
		logic [63:0] r;
		int unsigned mode;
		for (int i = 0; i <= int'(REG_INTEGRAL_BOUND); i++) begin
			r    = {$urandom, $urandom};
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				r = '0;
			end else if (mode == 1) begin
				r = '1;
			end else if (mode >= 4) begin
				case (4'(i))
					REG_RPM_PER_COUNT:  r = 64'($urandom_range(32'h40, 32'h4000));
					REG_FILTER_GAIN:    r = 64'($urandom_range(32'h1000, 32'hFFFF));
					REG_INTEGRAL_GATE:  r = 64'($urandom_range(32'h100, 32'h40000));
					REG_OUTPUT_LIMIT:   r = 64'($urandom_range(0, 25600));
					REG_INTEGRAL_BOUND: r = 64'($urandom_range(1, 32'h100000));
					default:            r = 64'($urandom_range(1, 32'h400));  // gains
				endcase
			end
			queue_reg_write(4'(i), r[38:0]);
		end
		// index past the register file, must be dropped
		if ($urandom_range(0, 2) == 0)
			queue_reg_write(REG_INTEGRAL_BOUND + 4'($urandom_range(1, 8)), r[38:0]);
	endtask

	// Mostly runs with a held target and a slowly wandering delta, so the
	// filter settles and the integral gets to build up; some raw noise too.
	task automatic queue_random_ticks(input int n);
		logic [63:0] r;
		int target, span, base, len, d;
		while (n > 0) begin
			if ($urandom_range(0, 7) == 0) begin
				r = {$urandom, $urandom};
				tick_queue.push_back(r[39:0]);
				n--;
			end else begin
				case ($urandom_range(0, 9))
					0:       target = 0;
					1:       target = $urandom_range(0, 1) ? TMAX : -TMAX;
					2:       target = $urandom_range(0, 24'hFFFFFF) - 8388608;
					default: target = $urandom_range(0, 2 * TMAX) - TMAX;
				endcase
				case ($urandom_range(0, 2))
					0:       span = 16;
					1:       span = 512;
					default: span = 32767;
				endcase
				base = $urandom_range(0, 2 * span) - span;
				len  = $urandom_range(3, 30);
				if (len > n)
					len = n;
				repeat (len) begin
					d = base + int'($urandom_range(0, 2 * (span / 8) + 2)) - (span / 8 + 1);
					if (d > 32767)
						d = 32767;
					if (d < -32768)
						d = -32768;
					queue_tick(d, target);
				end
				n -= len;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		regs_to_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// register defaults: zero scale, so the measured speed stays at 0
		queue_tick(1234, 5000);
		queue_tick(-500, 0);
		wait_quiet();

		// full scale: raw speed saturates, wide-open gate, tight integral clamp
		queue_reg_write(REG_RPM_PER_COUNT, 39'hFF_FFFF);
		queue_reg_write(REG_FILTER_GAIN, 39'hFFFF);
		queue_reg_write(REG_GAIN_P, 39'h0100);
		queue_reg_write(REG_GAIN_I, 39'h0080);
		queue_reg_write(REG_GAIN_D, 39'h0040);
		queue_reg_write(REG_INTEGRAL_GATE, 39'hFF_FFFF);
		queue_reg_write(REG_OUTPUT_LIMIT, {24'hA5A5A5, 15'd25600});  // upper bits dropped
		queue_reg_write(REG_INTEGRAL_BOUND, 39'd2000);
		queue_reg_write(REG_INTEGRAL_BOUND + 4'd1, '1);                // no such register
		queue_reg_write(REG_INTEGRAL_BOUND + 4'd8, '1);
		flush_reg_writes();
		queue_tick(0, 0);
		queue_tick(32767, 8388607);         // raw and target both clip high
		queue_tick(-32768, -8388608);       // and low
		queue_tick(1, TMAX);
		queue_tick(-1, -TMAX);
		queue_tick(0, 1);
		queue_tick(0, TMAX + 1);
		queue_tick(1, 1000);                // integral runs into the clamp
		queue_tick(1, 1000);
		queue_tick(1, 1000);
		queue_tick(0, 0);                   // clear
		queue_tick(1, 5000);                // derivative sees the full error
		flush_reg_writes();
		wait_quiet();

		// integral disabled by a zero gain
		queue_reg_write(REG_RPM_PER_COUNT, 39'h100);
		queue_reg_write(REG_GAIN_I, '0);
		queue_reg_write(REG_GAIN_D, '0);
		flush_reg_writes();
		queue_tick(100, 300);
		queue_tick(100, 300);
		queue_tick(-50, -300);
		wait_quiet();

		// narrow gate: open for a settled speed, closed on a large error
		queue_reg_write(REG_GAIN_I, 39'h200);
		queue_reg_write(REG_INTEGRAL_GATE, 39'h100);
		flush_reg_writes();
		queue_tick(100, 100);
		queue_tick(100, 100);
		queue_tick(5000, 100);
		wait_quiet();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			queue_random_settings();
			flush_reg_writes();
			if (p == RANDOM_PHASES - 1)
				jitter_on <= 1'b0;          // final stretch at full rate
			if (p == 2)
				long_hold_req <= 1'b1;
			queue_random_ticks((p == RANDOM_PHASES - 1) ? 150 : $urandom_range(105, 130));
			wait_quiet();
		end

		$display("summary: %0d ticks, %0d results, %0d register writes over %0d settings",
			ticks_in, results_seen, cfg_writes, settings);
		$display("summary: integral active %0d, drive clipped %0d, zero-target clears %0d",
			integ_ticks, sat_ticks, clear_ticks);
		if (mismatches == 0) begin
			$display("tb_encoder_speed_pid: done, clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb_encoder_speed_pid: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
design/esp_pkg.sv
design/esp_cfg.sv
design/esp_ctrl.sv
design/esp_dp.sv
design/encoder_speed_pid.sv
design/esp_checker.sv
tb/tb_encoder_speed_pid.sv
